FILE: hw/rtl/spq_pkg.sv
// Package for the sorted priority queue: depth constants, codes, word types.
// Used by spq_ctrl and sorted_priority_queue_core.
package spq_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 4;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_PULL   = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] item_value;
    logic signed [15:0] item_priority;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pulled_value;
    logic signed [15:0] pulled_priority;
    logic               head_valid;
    logic signed [31:0] head_value;
    logic signed [15:0] head_priority;
    logic [3:0]         entry_count;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic signed [31:0] value;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_HEAD,
    S_PULL_MV,
    S_REPORT
  } state_t;

endpackage

FILE: hw/rtl/spq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No package dependency.
module spq_ram #(
  parameter int AW = 3,
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/spq_ctrl.sv
// Queue sequencer: walks the entry RAM to shift entries on insert and pull,
// keeps the head entry and count in registers. Depends on spq_pkg, spq_ram.
module spq_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  spq_pkg::in_word_t       in_data,
  input  logic [spq_pkg::CAP_W-1:0] cap,
  output logic                    busy,
  output logic                    out_strobe,
  output spq_pkg::out_word_t      out_data
);
  import spq_pkg::*;

  state_t state_r, state_nxt;
  in_word_t item_r, item_nxt;
  entry_t head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0] status_r, status_nxt;
  entry_t pulled_r, pulled_nxt;

  logic we, re;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t wdata, rdata;
  logic [$bits(entry_t)-1:0] rdata_raw;

  logic full_w, ins_stop_w, idx_one_w, pull_last_w;
  logic [CMP_W-1:0] cnt_ext;
  entry_t new_entry;

  spq_ram #(.AW(IDX_W), .DW($bits(entry_t))) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (re),
    .raddr  (raddr),
    .rdata_r(rdata_raw)
  );

  assign rdata       = entry_t'(rdata_raw);
  assign cnt_ext     = CMP_W'(count_r);
  assign full_w      = (cnt_ext >= CMP_W'(cap)) || (count_r >= CNT_W'(DEPTH));
  assign ins_stop_w  = rdata.prio <= item_r.item_priority;
  assign idx_one_w   = idx_r == IDX_W'(1);
  assign pull_last_w = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
  assign new_entry   = '{prio: item_r.item_priority, value: item_r.item_value};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.kind == KIND_INSERT) begin
            state_nxt = (full_w || count_r == '0) ? S_REPORT : S_INS_CMP;
          end else begin
            state_nxt = (count_r <= CNT_W'(1)) ? S_REPORT : S_PULL_MV;
          end
        end
      end
      S_INS_CMP: begin
        if (ins_stop_w) begin
          state_nxt = S_REPORT;
        end else if (idx_one_w) begin
          state_nxt = S_INS_HEAD;
        end
      end
      S_INS_HEAD: state_nxt = S_REPORT;
      S_PULL_MV: begin
        if (pull_last_w) begin
          state_nxt = S_REPORT;
        end
      end
      S_REPORT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    item_nxt   = item_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    pulled_nxt = pulled_r;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = '0;
    raddr      = '0;
    wdata      = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt   = in_data;
          status_nxt = ST_DONE;
          pulled_nxt = '0;
          if (in_data.kind == KIND_INSERT) begin
            if (full_w) begin
              status_nxt = ST_FULL;
            end else if (count_r == '0) begin
              we        = 1'b1;
              wdata     = '{prio: in_data.item_priority, value: in_data.item_value};
              head_nxt  = '{prio: in_data.item_priority, value: in_data.item_value};
              count_nxt = CNT_W'(1);
            end else begin
              // start the walk at the tail
              re      = 1'b1;
              raddr   = IDX_W'(count_r - CNT_W'(1));
              idx_nxt = IDX_W'(count_r);
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              pulled_nxt = head_r;
              if (count_r == CNT_W'(1)) begin
                count_nxt = '0;
              end else begin
                re      = 1'b1;
                raddr   = IDX_W'(1);
                idx_nxt = IDX_W'(1);
              end
            end
          end
        end
      end
      S_INS_CMP: begin
        we    = 1'b1;
        waddr = idx_r;
        if (ins_stop_w) begin
          wdata     = new_entry;
          count_nxt = count_r + CNT_W'(1);
        end else begin
          // move the larger entry one slot back
          wdata   = rdata;
          idx_nxt = idx_r - IDX_W'(1);
          if (!idx_one_w) begin
            re    = 1'b1;
            raddr = idx_r - IDX_W'(2);
          end
        end
      end
      S_INS_HEAD: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = new_entry;
        head_nxt  = new_entry;
        count_nxt = count_r + CNT_W'(1);
      end
      S_PULL_MV: begin
        we    = 1'b1;
        waddr = idx_r - IDX_W'(1);
        wdata = rdata;
        if (idx_one_w) begin
          head_nxt = rdata;
        end
        if (pull_last_w) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          re      = 1'b1;
          raddr   = idx_r + IDX_W'(1);
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_REPORT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    head_r   <= head_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    pulled_r <= pulled_nxt;
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = state_r == S_REPORT;

  always_comb begin
    out_data.status          = status_r;
    out_data.pulled_value    = pulled_r.value;
    out_data.pulled_priority = pulled_r.prio;
    out_data.head_valid      = count_r != '0;
    out_data.head_value      = (count_r != '0) ? head_r.value : '0;
    out_data.head_priority   = (count_r != '0) ? head_r.prio : '0;
    out_data.entry_count     = cnt_ext[3:0];
  end

endmodule

FILE: hw/rtl/sorted_priority_queue_core.sv
// Sorted priority queue top level: capacity register and the queue sequencer.
// Depends on spq_pkg and spq_ctrl.
//
//   channel  ports                          handshake
//   in       start, busy, in_data           taken when start & !busy
//   out      out_strobe, out_data           one cycle per word, no stall
//   cfg      cfg_we, cfg_wdata              written when cfg_we
//
// A refused word, an insert into an empty queue and a pull of the last entry
// give their result in the cycle after acceptance. Other inserts move each
// larger entry one slot back from the tail, then write the new entry; other
// pulls move each remaining entry one slot forward. The single entry RAM
// port pair sets this: one entry moved per cycle. busy holds from acceptance
// through the result cycle. Reset empties the queue and sets capacity to 8.
module sorted_priority_queue_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  spq_pkg::in_word_t         in_data,
  output logic                      out_strobe,
  output spq_pkg::out_word_t        out_data,
  input  logic                      cfg_we,
  input  logic [spq_pkg::CAP_W-1:0] cfg_wdata
);
  import spq_pkg::*;

  logic [CAP_W-1:0] cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cap       (cap_r),
    .busy      (busy),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

endmodule
